// File: design/tvcf_pkg.sv
// ----------------------------------------------------------------------------
// Trace value change filter package
// Field widths, beat payload types and register codes shared by the design.
// ----------------------------------------------------------------------------
package tvcf_pkg;

  localparam int unsigned SRC_W   = 2;
  localparam int unsigned SIG_W   = 6;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 1'b0,
    CFG_WINDOW_STOP  = 1'b1
  } cfg_reg_e;

  // Kind of one result beat.
  typedef enum logic {
    KIND_MARKER = 1'b0,
    KIND_CHANGE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SRC_W-1:0]   source;
    logic [SIG_W-1:0]   signal_id;
    logic [TIME_W-1:0]  sample_time;
    logic [VALUE_W-1:0] sample_value;
  } sample_t;

  typedef struct packed {
    kind_e              out_kind;
    logic [TIME_W-1:0]  out_time;
    logic [SRC_W-1:0]   out_source;
    logic [SIG_W-1:0]   out_signal;
    logic [VALUE_W-1:0] out_value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

endpackage

// File: design/tvcf_if.sv
// ----------------------------------------------------------------------------
// Trace value change filter channel interface
// Valid/ready channel carrying one payload beat of a configurable type.
// ----------------------------------------------------------------------------
interface tvcf_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// File: design/trace_value_change_filter_unit.sv
// ----------------------------------------------------------------------------
// Trace value change filter unit
// Drops samples outside the time window or table range and passes on only value
// changes and the first sample, each with a timestamp marker first when the time moves on.
// ----------------------------------------------------------------------------
// Pipeline: a sample beat is registered in the work stage and its result beats
// in the output stage, from which they are offered.
// Throughput: one sample per cycle while samples cause no result; a sample
// that emits holds the work stage until the output stage can take its beats, as
// the single result register is the bottleneck.
// Reset: all control state clears at once; the value table is cleared by a
// valid flag per entry, so no clearing pass is needed after reset.
module trace_value_change_filter_unit
  import tvcf_pkg::*;
#(
  parameter int SOURCE_COUNT = 4,
  parameter int SIGNAL_COUNT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tvcf_chan_if.sink   cfg_i,
  tvcf_chan_if.sink   sample_i,
  tvcf_chan_if.source result_o
);

  // Table geometry: only sources and signals that the fields can reach.
  localparam int EFF_SRC = (SOURCE_COUNT < (1 << SRC_W)) ? SOURCE_COUNT : (1 << SRC_W);
  localparam int EFF_SIG = (SIGNAL_COUNT < (1 << SIG_W)) ? SIGNAL_COUNT : (1 << SIG_W);
  localparam int SRC_IW  = (EFF_SRC > 1) ? $clog2(EFF_SRC) : 1;
  localparam int SIG_IW  = (EFF_SIG > 1) ? $clog2(EFF_SIG) : 1;
  localparam int ADDR_W  = SRC_IW + SIG_IW;
  localparam int DEPTH   = 1 << ADDR_W;

  // Window registers.
  logic [TIME_W-1:0] win_start_q, win_stop_q;

  // Time of the previous sample beat.
  logic [TIME_W-1:0] prev_time_q;
  logic              seen_first_q;

  // Value table and its per-entry valid flags.
  logic [VALUE_W-1:0] table_mem [DEPTH];
  logic [DEPTH-1:0]   entry_vld_q;

  // Work stage.
  logic               s1_vld_q;
  sample_t            s1_smp_q;
  logic               s1_pass_q;
  logic               s1_tdiff_q;
  logic [VALUE_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic               byp_q;
  logic [VALUE_W-1:0] byp_data_q;

  // Output stage.
  logic               out_mrk_q;
  logic               out_chg_q;
  logic [TIME_W-1:0]  out_time_q;
  logic [SRC_W-1:0]   out_src_q;
  logic [SIG_W-1:0]   out_sig_q;
  logic [VALUE_W-1:0] out_val_q;

  logic              in_acc, out_acc;
  logic              in_range, in_window;
  logic [ADDR_W-1:0] rd_idx, wr_idx;
  logic [VALUE_W-1:0] stored_val;
  logic              first, emit, out_free, s1_adv, wr_en;

  // Configuration port is always ready.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_stop_q  <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        CFG_WINDOW_START: win_start_q <= cfg_i.data.value[TIME_W-1:0];
        CFG_WINDOW_STOP:  win_stop_q  <= cfg_i.data.value[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side checks, done before the sample enters the work stage.
  assign in_acc    = sample_i.valid && sample_i.ready;
  assign in_window = (sample_i.data.sample_time >= win_start_q) &&
                     (sample_i.data.sample_time <= win_stop_q);
  assign in_range  = (int'(sample_i.data.source) < SOURCE_COUNT) &&
                     (int'(sample_i.data.signal_id) < SIGNAL_COUNT);
  assign rd_idx    = {sample_i.data.source[SRC_IW-1:0], sample_i.data.signal_id[SIG_IW-1:0]};
  assign wr_idx    = {s1_smp_q.source[SRC_IW-1:0], s1_smp_q.signal_id[SIG_IW-1:0]};

  // Stored value of the entry, with forwarding of a write on the read edge.
  assign stored_val = byp_q    ? byp_data_q :
                      rd_vld_q ? rd_data_q  : '0;

  // Decision for the sample in the work stage.
  assign first    = !seen_first_q;
  assign emit     = s1_pass_q && (first || (stored_val != s1_smp_q.sample_value));
  assign out_acc  = result_o.valid && result_o.ready;
  assign out_free = !out_chg_q || (out_acc && !out_mrk_q);
  assign s1_adv   = s1_vld_q && (!emit || out_free);
  assign wr_en    = s1_adv && emit;

  assign sample_i.ready = !s1_vld_q || s1_adv;

  // Work stage control, previous sample time and table valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      prev_time_q  <= '0;
      seen_first_q <= 1'b0;
      entry_vld_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q    <= 1'b1;
        prev_time_q <= sample_i.data.sample_time;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (wr_en) begin
        seen_first_q        <= 1'b1;
        entry_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Work stage payload and table read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_smp_q   <= sample_i.data;
      s1_pass_q  <= in_window && in_range;
      s1_tdiff_q <= sample_i.data.sample_time != prev_time_q;
      rd_data_q  <= table_mem[rd_idx];
      rd_vld_q   <= entry_vld_q[rd_idx];
      byp_q      <= wr_en && (wr_idx == rd_idx);
      byp_data_q <= s1_smp_q.sample_value;
    end
  end

  // Table write of every emitted value.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_idx] <= s1_smp_q.sample_value;
    end
  end

  // Output stage: an optional marker beat, then the change beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mrk_q <= 1'b0;
      out_chg_q <= 1'b0;
    end else if (wr_en) begin
      out_mrk_q <= first || s1_tdiff_q;
      out_chg_q <= 1'b1;
    end else if (out_acc) begin
      if (out_mrk_q) begin
        out_mrk_q <= 1'b0;
      end else begin
        out_chg_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_time_q <= s1_smp_q.sample_time;
      out_src_q  <= s1_smp_q.source;
      out_sig_q  <= s1_smp_q.signal_id;
      out_val_q  <= s1_smp_q.sample_value;
    end
  end

  // Result beat: a marker carries only the time.
  always_comb begin
    result_o.valid         = out_chg_q;
    result_o.data.out_time = out_time_q;
    if (out_mrk_q) begin
      result_o.data.out_kind   = KIND_MARKER;
      result_o.data.out_source = '0;
      result_o.data.out_signal = '0;
      result_o.data.out_value  = '0;
      result_o.data.last       = 1'b0;
    end else begin
      result_o.data.out_kind   = KIND_CHANGE;
      result_o.data.out_source = out_src_q;
      result_o.data.out_signal = out_sig_q;
      result_o.data.out_value  = out_val_q;
      result_o.data.last       = 1'b1;
    end
  end

  // A pending marker always has its change beat behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_mrk_q |-> out_chg_q)
    else $error("marker pending without a change beat");

  // A taken marker beat is followed by the change beat of the same sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && (result_o.data.out_kind == KIND_MARKER)) |=>
      (result_o.valid && (result_o.data.out_kind == KIND_CHANGE) &&
       $stable(out_time_q)))
    else $error("marker beat not followed by its change beat");

  // The sample side only stalls while the work stage holds a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !sample_i.ready |-> s1_vld_q)
    else $error("sample side stalled with an empty work stage");

  // Once a sample has been emitted the first-sample flag stays set.
  assert property (@(posedge clk_i) disable iff (!rst_ni) seen_first_q |=> seen_first_q)
    else $error("first-sample flag cleared outside reset");

endmodule
